// ===== src/bt_pkg.sv =====
// Shared types and constants for the bencode tokenizer.
`timescale 1ns / 1ps

package bt_pkg;

  // Default width of the integer and length accumulator.
  localparam int VALUE_BITS_DEF = 32;

  // Width of the number field on the result channel.
  localparam int NUM_W = 32;

  // Result queue depth; two free entries are needed per input byte.
  localparam int FIFO_DEPTH = 4;

  // Byte codes that the lexer recognizes.
  localparam logic [7:0] CH_LIST  = 8'h6c;
  localparam logic [7:0] CH_DICT  = 8'h64;
  localparam logic [7:0] CH_END   = 8'h65;
  localparam logic [7:0] CH_IMARK = 8'h69;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Token kinds on the result channel.
  typedef enum logic [2:0] {
    KIND_LIST  = 3'd0,
    KIND_DICT  = 3'd1,
    KIND_END   = 3'd2,
    KIND_IMARK = 3'd3,
    KIND_INT   = 3'd4,
    KIND_SBYTE = 3'd5,
    KIND_EMPTY = 3'd6
  } tok_kind_t;

  // One result item.
  typedef struct packed {
    tok_kind_t         token_kind;
    logic [7:0]        string_byte;
    logic [NUM_W-1:0]  number;
    logic              string_end;
    logic              overflow;
    logic              last;
  } tok_t;

  // Up to two results written into the queue in one cycle, in order.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       e0;
    tok_t       e1;
  } bt_wr_t;

endpackage

// ===== src/bt_in_if.sv =====
// Input byte channel of the bencode tokenizer.
`timescale 1ns / 1ps

interface bt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== src/bt_out_if.sv =====
// Token result channel of the bencode tokenizer.
`timescale 1ns / 1ps

interface bt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  string_byte;
  logic [31:0] number;
  logic        string_end;
  logic        overflow;
  logic        last;

  modport source (output valid, output token_kind, output string_byte, output number,
                  output string_end, output overflow, output last, input ready);
  modport sink   (input valid, input token_kind, input string_byte, input number,
                  input string_end, input overflow, input last, output ready);
endinterface

// ===== src/bt_lex_core.sv =====
// Input register, lexer state and per-byte token logic.
`timescale 1ns / 1ps

module bt_lex_core import bt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_data,
  input  logic       room,
  output bt_wr_t     wr
);

  localparam int LB = VALUE_BITS - 1;
  localparam int PW = VALUE_BITS + 4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_STR  = 2'd2
  } mode_t;

  // Input stage.
  logic            in_v_r;
  logic [7:0]      byte_r;
  logic            eod_r;
  logic            adv;

  // Lexer state.
  mode_t           mode_r, mode_nxt;
  logic            neg_r, neg_nxt;
  logic [LB:0]     acc_r, acc_nxt;
  logic            dig_r, dig_nxt;
  logic [LB-1:0]   rem_r, rem_nxt;
  logic [LB-1:0]   slen_r, slen_nxt;
  logic            sat_r, sat_nxt;

  // Digit accumulate datapath.
  logic            is_digit;
  logic [3:0]      dval;
  logic [LB:0]     run_acc;
  logic            run_neg;
  logic            run_sat;
  logic [LB:0]     lim;
  logic [PW-1:0]   acc_w;
  logic [PW-1:0]   prod;
  logic            sum_ovf;
  logic [LB:0]     sum_acc;

  // Candidate results: main token, single-byte token, end-of-data flush.
  tok_t            res_a, res_b, res_f;
  logic            a_v, b_v, f_v;
  logic            tok_v;
  tok_kind_t       tok_kind;
  logic [1:0]      cnt;
  logic [63:0]     len_w;

  // Signed value of a run as the low bits of its two's complement form.
  function automatic logic [NUM_W-1:0] int_number(input logic [LB:0] mag, input logic neg);
    logic [LB:0]        v;
    logic signed [63:0] w;
    v = neg ? (~mag + 1'b1) : mag;
    w = 64'(signed'(v));
    return w[NUM_W-1:0];
  endfunction

  // The stage moves on when the queue can take two results.
  assign adv      = in_v_r && room;
  assign in_ready = !in_v_r || adv;

  // Byte classes and the next digit value.
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign dval     = 4'(byte_r - CH_ZERO);

  // A digit in idle starts a fresh run; in a run it extends the run.
  assign run_acc  = (mode_r == MODE_NUM) ? acc_r : '0;
  assign run_neg  = (mode_r == MODE_NUM) ? neg_r : 1'b0;
  assign run_sat  = (mode_r == MODE_NUM) ? sat_r : 1'b0;
  assign lim      = {1'b0, {LB{1'b1}}} + (LB+1)'(run_neg);
  assign acc_w    = PW'(run_acc);
  assign prod     = (acc_w << 3) + (acc_w << 1) + PW'(dval);
  assign sum_ovf  = run_sat || (prod > PW'(lim));
  assign sum_acc  = sum_ovf ? lim : prod[LB:0];

  // Single-byte structure tokens.
  always_comb begin
    tok_v    = 1'b1;
    tok_kind = KIND_LIST;
    unique case (byte_r)
      CH_LIST:  tok_kind = KIND_LIST;
      CH_DICT:  tok_kind = KIND_DICT;
      CH_END:   tok_kind = KIND_END;
      CH_IMARK: tok_kind = KIND_IMARK;
      default:  tok_v    = 1'b0;
    endcase
  end

  assign len_w = 64'(slen_r);

  // Next state and results for the byte in the input stage.
  always_comb begin
    mode_nxt = mode_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    rem_nxt  = rem_r;
    slen_nxt = slen_r;
    sat_nxt  = sat_r;
    a_v      = 1'b0;
    b_v      = 1'b0;
    f_v      = 1'b0;
    res_a    = '0;
    res_b    = '0;
    res_f    = '0;

    res_b.token_kind = tok_kind;

    unique case (mode_r)
      MODE_STR: begin
        a_v              = 1'b1;
        res_a.token_kind = KIND_SBYTE;
        res_a.string_byte = byte_r;
        res_a.number     = len_w[NUM_W-1:0];
        res_a.string_end = (rem_r == (LB)'(1));
        res_a.overflow   = sat_r;
        if (rem_r != '0) begin
          rem_nxt = rem_r - 1'b1;
        end
        if (rem_r <= (LB)'(1)) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        priority if (is_digit) begin
          acc_nxt = sum_acc;
          sat_nxt = sum_ovf;
          dig_nxt = 1'b1;
        end else if (byte_r == CH_COLON && dig_r && !neg_r) begin
          // Length prefix complete: start a string or give an empty one.
          if (acc_r == '0) begin
            a_v              = 1'b1;
            res_a.token_kind = KIND_EMPTY;
            res_a.overflow   = sat_r;
            mode_nxt         = MODE_IDLE;
          end else begin
            slen_nxt = acc_r[LB-1:0];
            rem_nxt  = acc_r[LB-1:0];
            mode_nxt = MODE_STR;
          end
        end else begin
          // The run ends; the byte is then lexed on its own.
          if (dig_r) begin
            a_v              = 1'b1;
            res_a.token_kind = KIND_INT;
            res_a.number     = int_number(acc_r, neg_r);
            res_a.overflow   = sat_r;
          end
          mode_nxt = MODE_IDLE;
          b_v      = tok_v;
          if (byte_r == CH_MINUS) begin
            neg_nxt  = 1'b1;
            acc_nxt  = '0;
            dig_nxt  = 1'b0;
            sat_nxt  = 1'b0;
            mode_nxt = MODE_NUM;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        b_v      = tok_v;
        if (byte_r == CH_MINUS) begin
          neg_nxt  = 1'b1;
          acc_nxt  = '0;
          dig_nxt  = 1'b0;
          sat_nxt  = 1'b0;
          mode_nxt = MODE_NUM;
        end else if (is_digit) begin
          neg_nxt  = 1'b0;
          acc_nxt  = sum_acc;
          dig_nxt  = 1'b1;
          sat_nxt  = sum_ovf;
          mode_nxt = MODE_NUM;
        end
      end
    endcase

    // End of data flushes a pending integer and returns to reset state.
    if (eod_r) begin
      if (mode_nxt == MODE_NUM && dig_nxt) begin
        f_v              = 1'b1;
        res_f.token_kind = KIND_INT;
        res_f.number     = int_number(acc_nxt, neg_nxt);
        res_f.overflow   = sat_nxt;
      end
      mode_nxt = MODE_IDLE;
      neg_nxt  = 1'b0;
      acc_nxt  = '0;
      dig_nxt  = 1'b0;
      rem_nxt  = '0;
      slen_nxt = '0;
      sat_nxt  = 1'b0;
    end
  end

  // Pack the results in order into at most two queue writes.
  always_comb begin
    cnt = 2'(a_v) + 2'(b_v) + 2'(f_v);
    wr.e0 = a_v ? res_a : (b_v ? res_b : res_f);
    wr.e1 = a_v ? (b_v ? res_b : res_f) : res_f;
    wr.e0.last = (cnt == 2'd1);
    wr.e1.last = 1'b1;
    wr.cnt = adv ? cnt : 2'd0;
  end

  // Input stage and lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= MODE_IDLE;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      dig_r  <= 1'b0;
      rem_r  <= '0;
      slen_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        mode_r <= mode_nxt;
        neg_r  <= neg_nxt;
        acc_r  <= acc_nxt;
        dig_r  <= dig_nxt;
        rem_r  <= rem_nxt;
        slen_r <= slen_nxt;
        sat_r  <= sat_nxt;
      end
    end
    if (in_ready && in_valid) begin
      byte_r <= data_byte;
      eod_r  <= end_of_data;
    end
  end

endmodule

// ===== src/bt_out_fifo.sv =====
// Result queue that takes up to two tokens per cycle and gives one.
`timescale 1ns / 1ps

module bt_out_fifo import bt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  bt_wr_t wr,
  output logic   room,
  output logic   out_valid,
  input  logic   out_ready,
  output tok_t   out_tok
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tok_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_1;
  logic             pop;

  // Two free entries are kept for every byte the core may process.
  assign room      = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_tok   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr_r + 1'b1;

  // Entry writes.
  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr.e0;
    end
    if (wr.cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= wr.e1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(wr.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(wr.cnt) - CNT_W'(pop);
    end
  end

endmodule

// ===== src/bencode_tokenizer_top.sv =====
// Top level of the bencode tokenizer.
//
//   Channel | Direction | Handshake     | Payload
//   in_ch   | sink      | valid / ready | data_byte, end_of_data
//   out_ch  | source    | valid / ready | token_kind, string_byte, number,
//           |           |               | string_end, overflow, last
//
// One byte is taken per cycle while the queue has room; its tokens pass the input
// register and the result queue, then leave one per cycle while out_ch is ready.
// A byte that yields two tokens gives them as two transfers, in order.
// The input stage advances while the four-entry result queue has two free entries.
// Synchronous active-low reset returns the lexer to idle and empties the queue.
`timescale 1ns / 1ps

module bencode_tokenizer_top import bt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bt_in_if.sink      in_ch,
  bt_out_if.source   out_ch
);

  bt_wr_t wr;
  logic   room;
  tok_t   out_tok;

  // Lexer with its input register.
  bt_lex_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .data_byte   (in_ch.data_byte),
    .end_of_data (in_ch.end_of_data),
    .room        (room),
    .wr          (wr)
  );

  // Result queue.
  bt_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_tok   (out_tok)
  );

  // Result channel payload.
  assign out_ch.token_kind  = out_tok.token_kind;
  assign out_ch.string_byte = out_tok.string_byte;
  assign out_ch.number      = out_tok.number;
  assign out_ch.string_end  = out_tok.string_end;
  assign out_ch.overflow    = out_tok.overflow;
  assign out_ch.last        = out_tok.last;

endmodule

// ===== bench/bencode_tokenizer_top_tb.sv =====
// Self-checking testbench for the bencode tokenizer: directed and random byte streams.
`timescale 1ns / 1ps

module bencode_tokenizer_top_tb import bt_pkg::*;;

  // Lexer modes of the token predictor.
  typedef enum logic [1:0] {
    LX_IDLE = 2'd0,
    LX_RUN  = 2'd1,
    LX_STR  = 2'd2
  } lex_mode_t;

  localparam longint unsigned POS_LIM     = 64'h7fff_ffff;
  localparam int              QUIET_LIMIT = 3000;
  localparam int              DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  bt_in_if  in_ch ();
  bt_out_if out_ch ();

  bencode_tokenizer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state.
  lex_mode_t       lex_mode;
  logic            run_neg;
  longint unsigned run_mag;
  logic            run_has_digit;
  logic            run_sat;
  longint unsigned str_left;
  longint unsigned str_len;

  // Tokens predicted but not yet seen, and the one held back to get its last flag.
  tok_t tokens_due[$];
  tok_t held_tok;
  logic held_valid;

  // Bytes of the sequence being built for the next burst of transfers.
  logic [7:0] stream_q[$];

  int err_count;
  int sent_bytes;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  task automatic put_tok(tok_kind_t kind, logic [7:0] sb, logic [31:0] num,
                         logic send, logic ovf);
    tok_t t;
    if (held_valid) tokens_due.push_back(held_tok);
    t.token_kind  = kind;
    t.string_byte = sb;
    t.number      = num;
    t.string_end  = send;
    t.overflow    = ovf;
    t.last        = 1'b0;
    held_tok   = t;
    held_valid = 1'b1;
  endtask

  task automatic clear_run();
    run_neg       = 1'b0;
    run_mag       = 64'd0;
    run_has_digit = 1'b0;
    run_sat       = 1'b0;
  endtask

  task automatic reset_lexer();
    lex_mode = LX_IDLE;
    clear_run();
    str_left = 64'd0;
    str_len  = 64'd0;
  endtask

  // Add one decimal digit, clamping at the signed limit of the run's sign.
  task automatic add_digit(logic [7:0] b);
    longint unsigned lim;
    longint unsigned d;
    d   = 64'(b - CH_ZERO);
    lim = POS_LIM + (run_neg ? 64'd1 : 64'd0);
    if (run_sat || run_mag > (lim - d) / 10) begin
      run_mag = lim;
      run_sat = 1'b1;
    end else begin
      run_mag = run_mag * 10 + d;
    end
    run_has_digit = 1'b1;
  endtask

  task automatic emit_integer();
    longint unsigned v;
    v = run_neg ? (64'd0 - run_mag) : run_mag;
    put_tok(KIND_INT, 8'h00, v[31:0], 1'b0, run_sat);
  endtask

  // A byte seen outside any run or string.
  task automatic lex_plain(logic [7:0] b);
    lex_mode = LX_IDLE;
    case (b)
      CH_LIST:  put_tok(KIND_LIST, 8'h00, 32'd0, 1'b0, 1'b0);
      CH_DICT:  put_tok(KIND_DICT, 8'h00, 32'd0, 1'b0, 1'b0);
      CH_END:   put_tok(KIND_END, 8'h00, 32'd0, 1'b0, 1'b0);
      CH_IMARK: put_tok(KIND_IMARK, 8'h00, 32'd0, 1'b0, 1'b0);
      CH_MINUS: begin
        clear_run();
        run_neg  = 1'b1;
        lex_mode = LX_RUN;
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          clear_run();
          add_digit(b);
          lex_mode = LX_RUN;
        end
      end
    endcase
  endtask

  // The length prefix is complete; an empty string is reported at once.
  task automatic start_string();
    longint unsigned len;
    len = run_mag;
    if (len > POS_LIM) begin
      len     = POS_LIM;
      run_sat = 1'b1;
    end
    if (len == 0) begin
      put_tok(KIND_EMPTY, 8'h00, 32'd0, 1'b0, run_sat);
      lex_mode = LX_IDLE;
    end else begin
      str_len  = len;
      str_left = len;
      lex_mode = LX_STR;
    end
  endtask

  // Work out the tokens that one accepted byte causes and queue them.
  task automatic predict_tokens(logic [7:0] b, logic eod);
    held_valid = 1'b0;
    case (lex_mode)
      LX_STR: begin
        put_tok(KIND_SBYTE, b, str_len[31:0], str_left == 1, run_sat);
        if (str_left > 0) str_left--;
        if (str_left == 0) lex_mode = LX_IDLE;
      end
      LX_RUN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          add_digit(b);
        end else if (b == CH_COLON && run_has_digit && !run_neg) begin
          start_string();
        end else begin
          if (run_has_digit) emit_integer();
          lex_plain(b);
        end
      end
      default: lex_plain(b);
    endcase
    if (eod) begin
      if (lex_mode == LX_RUN && run_has_digit) emit_integer();
      reset_lexer();
    end
    if (held_valid) begin
      held_tok.last = 1'b1;
      tokens_due.push_back(held_tok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One byte transfer, preceded by random idle cycles on the input side.
  task automatic send_byte(logic [7:0] b, logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_data <= eod;
    do @(posedge clk); while (!in_ch.ready);
    predict_tokens(b, eod);
    sent_bytes++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  // Send the built sequence; optionally mark its final byte as end of data.
  task automatic send_stream(logic eod_last);
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], eod_last && (i == stream_q.size() - 1));
    stream_q.delete();
  endtask

  task automatic push_digits(int n);
    stream_q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
    for (int i = 1; i < n; i++) stream_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  // A decimal run, optionally signed: mostly small, sometimes long, at the limits or zero-padded.
  task automatic push_number(logic allow_sign);
    int pick;
    pick = $urandom_range(99);
    if (allow_sign && $urandom_range(1)) push_text("-");
    if (pick < 70) begin
      push_text($sformatf("%0d", $urandom_range(999)));
    end else if (pick < 80) begin
      push_digits($urandom_range(10, 12));
    end else if (pick < 90) begin
      push_text($urandom_range(1) ? "2147483647" : "2147483648");
    end else begin
      push_text($sformatf("00%0d", $urandom_range(99)));
    end
  endtask

  task automatic push_string(int len);
    if ($urandom_range(99) < 15) push_text("0");
    push_text($sformatf("%0d:", len));
    repeat (len) stream_q.push_back(8'($urandom_range(255)));
  endtask

  // Truncated strings, lone signs and flushed runs, all closed by end of data.
  task automatic send_broken();
    int len;
    logic [7:0] b;
    case ($urandom_range(2))
      0: begin
        len = $urandom_range(3, 9);
        push_text($sformatf("%0d:", len));
        repeat ($urandom_range(len - 1)) stream_q.push_back(8'($urandom_range(255)));
      end
      1: begin
        b = 8'($urandom_range(255));
        if (b >= CH_ZERO && b <= CH_NINE) b = "z";
        stream_q.push_back(CH_MINUS);
        stream_q.push_back(b);
      end
      default: push_number(1'b1);
    endcase
    send_stream(1'b1);
  endtask

  // One random sequence, well formed most of the time.
  task automatic send_random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(3))
        0: push_text("l");
        1: push_text("d");
        2: push_text("e");
        default: push_text("i");
      endcase
      send_stream($urandom_range(99) < 4);
    end else if (pick < 45) begin
      if ($urandom_range(99) < 80) push_text("i");
      push_number(1'b1);
      push_text("e");
      send_stream($urandom_range(99) < 4);
    end else if (pick < 80) begin
      push_string(($urandom_range(99) < 5) ? $urandom_range(20, 40) : $urandom_range(8));
      send_stream($urandom_range(99) < 4);
    end else if (pick < 90) begin
      stream_q.push_back(8'($urandom_range(255)));
      send_stream($urandom_range(99) < 4);
    end else begin
      send_broken();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_markers();
    push_text("ldie");
    send_stream(1'b0);
  endtask

  // Minus zero ended by a marker gives two tokens; a signed run ended by ':'
  // is an integer and the colon is dropped; a lone minus is dropped; end of
  // data flushes a pending run.
  task automatic test_integers();
    push_text("-0e-5:-x42");
    send_stream(1'b1);
  endtask

  // Empty string, then a saturated length whose string is cut by end of data.
  task automatic test_strings();
    push_text("0:3000000000:");
    stream_q.push_back(8'hff);
    send_stream(1'b1);
  endtask

  task automatic test_unmatched();
    push_text(":");
    stream_q.push_back(8'h00);
    send_stream(1'b0);
  endtask

  task automatic test_random_traffic(int target);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < target) send_random_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Compare every token transfer with the oldest prediction.
  always @(posedge clk) begin : check_tokens
    tok_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: token with nothing outstanding, expected none, actual kind %0d number %0h",
                 $time, out_ch.token_kind, out_ch.number);
        err_count++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", 32'(want.token_kind), 32'(out_ch.token_kind));
        check_field("string_byte", 32'(want.string_byte), 32'(out_ch.string_byte));
        check_field("number", want.number, out_ch.number);
        check_field("string_end", 32'(want.string_end), 32'(out_ch.string_end));
        check_field("overflow", 32'(want.overflow), 32'(out_ch.overflow));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // Random back-pressure on the token channel.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run if neither channel sees a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bencode_tokenizer_top_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    err_count         = 0;
    sent_bytes        = 0;
    held_valid        = 1'b0;
    send_idle_pct     = 38;
    recv_idle_pct     = 86;
    reset_lexer();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= 8'h00;
    in_ch.end_of_data <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_markers();
    test_integers();
    test_strings();
    test_unmatched();
    test_random_traffic(500);

    send_idle_pct = 86;
    recv_idle_pct = 38;
    test_random_traffic(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(500);

    // Drain the outstanding tokens, then allow for the pipeline latency.
    in_ch.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("bencode_tokenizer_top_tb: clean");
    end else begin
      $display("bencode_tokenizer_top_tb: errors");
    end
    $finish;
  end

endmodule
